/* rtl/hsv2rgb_pkg.sv */
// Shared constants and types for the HSV to RGB converter.
`default_nettype none

package hsv2rgb_pkg;

    // default channel width of saturation, value and RGB codes
    localparam int COLOR_BITS_DEF = 8;

    // hue field: whole degrees, fixed width
    localparam int HUE_W      = 9;
    localparam int HUE_WRAP   = 360;
    localparam int SECTOR_DEG = 60;
    localparam int REM_W      = 6;

    typedef enum logic [2:0] {
        SEC_0,
        SEC_1,
        SEC_2,
        SEC_3,
        SEC_4,
        SEC_5
    } sector_t;

endpackage

`default_nettype wire

/* rtl/hsv_to_rgb_converter.sv */
// Pipelined HSV to RGB pixel converter, six-sector method.
`default_nettype none

// Channel  | Dir | Word fields (lowest bit up)                        | Handshake
// ---------+-----+----------------------------------------------------+------------------
// s_axis   | in  | hue_deg[8:0], saturation[N-1:0], brightness[N-1:0]  | s_tvalid/s_tready
// m_axis   | out | red[N-1:0], green[N-1:0], blue[N-1:0]               | m_tvalid/m_tready
//
// Eight register stages: a word accepted at the input passes through the
// stage 1 to stage 8 registers in order and leaves with m_tready.
// One word per cycle is accepted and delivered while m_tready stays high; the
// depth is set by the multiplier stages and the constant-divide correction chain.
// Each stage advances when it is empty or its word moves on, so bubbles
// are squeezed out and a stall at the output loses and repeats nothing.
// Reset (synchronous, active low) clears only the stage valid bits.

module hsv_to_rgb_converter #(
    parameter int COLOR_BITS = hsv2rgb_pkg::COLOR_BITS_DEF
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // hue_deg[8:0], saturation, brightness, zero padded to bytes
    input  wire logic [((hsv2rgb_pkg::HUE_W+2*COLOR_BITS+7)/8)*8-1:0] s_tdata,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // red, green, blue, zero padded to bytes
    output logic [((3*COLOR_BITS+7)/8)*8-1:0]          m_tdata,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready
);

    localparam int N     = COLOR_BITS;
    localparam int HW    = hsv2rgb_pkg::HUE_W;
    localparam int RW_   = hsv2rgb_pkg::REM_W;
    localparam int OTW   = ((3*N+7)/8)*8;
    localparam int NS    = 8;                 // pipeline stages
    localparam int LANES = 3;                 // p, q, t terms
    localparam int LANE_P = 0;
    localparam int LANE_Q = 1;
    localparam int LANE_T = 2;
    localparam int QW    = N + 6;             // holds 60*MAXC
    localparam int XW    = 2*N + 6;           // holds v*60*MAXC
    localparam int CW    = N + 2;             // divide remainder, < 3*MAXC
    localparam int K     = QW + 6;            // reciprocal shift for /60
    localparam int RCW   = K - 5;             // reciprocal width
    localparam int PW    = QW + RCW;

    localparam logic [N-1:0]   MAXC      = {N{1'b1}};
    localparam logic [QW-1:0]  DEN       = QW'(60 * ((1 << N) - 1));
    localparam logic [CW-1:0]  MAXC_C    = CW'((1 << N) - 1);
    localparam logic [CW-1:0]  MAXC2_C   = CW'(2 * ((1 << N) - 1));
    localparam logic [RCW-1:0] RECIP60   =
        RCW'(((64'd1 << K) + 64'd59) / 64'd60);
    localparam logic [HW-1:0]  WRAP_H    = HW'(hsv2rgb_pkg::HUE_WRAP);
    localparam logic [RW_-1:0] SEC_DEG_R = RW_'(hsv2rgb_pkg::SECTOR_DEG);

    // ---------------- handshake / stage control ----------------
    logic [NS-1:0] vld_reg, vld_next;
    logic [NS-1:0] stage_en;

    always_comb begin
        stage_en[NS-1] = !vld_reg[NS-1] || m_tready;
        for (int i = NS - 2; i >= 0; i--) begin
            stage_en[i] = !vld_reg[i] || stage_en[i+1];
        end
    end

    always_comb begin
        vld_next = vld_reg;
        if (stage_en[0]) begin
            vld_next[0] = s_tvalid;
        end
        for (int i = 1; i < NS; i++) begin
            if (stage_en[i]) begin
                vld_next[i] = vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_tready = stage_en[0];
    assign m_tvalid = vld_reg[NS-1];

    // ---------------- stage 1: hue wrap, sector, remainder ----------------
    logic [HW-1:0]        hue_in;
    logic [N-1:0]         sat_in, val_in;
    logic [HW-1:0]        hue_w;
    logic [HW-1:0]        sec_base;
    hsv2rgb_pkg::sector_t sec1_next, sec1_reg;
    logic [RW_-1:0]       rem1_next, rem1_reg;
    logic [N-1:0]         sat1_next, sat1_reg, val1_next, val1_reg;

    assign hue_in = s_tdata[HW-1:0];
    assign sat_in = s_tdata[HW+N-1:HW];
    assign val_in = s_tdata[HW+2*N-1:HW+N];

    always_comb begin
        hue_w = (hue_in >= WRAP_H) ? hue_in - WRAP_H : hue_in;
        if (hue_w >= HW'(5 * hsv2rgb_pkg::SECTOR_DEG)) begin
            sec1_next = hsv2rgb_pkg::SEC_5;
        end else if (hue_w >= HW'(4 * hsv2rgb_pkg::SECTOR_DEG)) begin
            sec1_next = hsv2rgb_pkg::SEC_4;
        end else if (hue_w >= HW'(3 * hsv2rgb_pkg::SECTOR_DEG)) begin
            sec1_next = hsv2rgb_pkg::SEC_3;
        end else if (hue_w >= HW'(2 * hsv2rgb_pkg::SECTOR_DEG)) begin
            sec1_next = hsv2rgb_pkg::SEC_2;
        end else if (hue_w >= HW'(hsv2rgb_pkg::SECTOR_DEG)) begin
            sec1_next = hsv2rgb_pkg::SEC_1;
        end else begin
            sec1_next = hsv2rgb_pkg::SEC_0;
        end
        case (sec1_next)
            hsv2rgb_pkg::SEC_1: sec_base = HW'(hsv2rgb_pkg::SECTOR_DEG);
            hsv2rgb_pkg::SEC_2: sec_base = HW'(2 * hsv2rgb_pkg::SECTOR_DEG);
            hsv2rgb_pkg::SEC_3: sec_base = HW'(3 * hsv2rgb_pkg::SECTOR_DEG);
            hsv2rgb_pkg::SEC_4: sec_base = HW'(4 * hsv2rgb_pkg::SECTOR_DEG);
            hsv2rgb_pkg::SEC_5: sec_base = HW'(5 * hsv2rgb_pkg::SECTOR_DEG);
            default:            sec_base = '0;
        endcase
        rem1_next = RW_'(hue_w - sec_base);
        sat1_next = sat_in;
        val1_next = val_in;
    end

    // ---------------- stage 2: numerator factors ----------------
    hsv2rgb_pkg::sector_t sec2_reg;
    logic [N-1:0]         val2_reg;
    logic [QW-1:0]        d2_next [LANES];
    logic [QW-1:0]        d2_reg  [LANES];

    always_comb begin
        d2_next[LANE_P] = QW'(MAXC - sat1_reg);
        d2_next[LANE_Q] = DEN - QW'(QW'(sat1_reg) * QW'(rem1_reg));
        d2_next[LANE_T] = DEN - QW'(QW'(sat1_reg) * QW'(SEC_DEG_R - rem1_reg));
    end

    // ---------------- stage 3: scale by value ----------------
    hsv2rgb_pkg::sector_t sec3_reg;
    logic [N-1:0]         val3_reg;
    logic [XW-1:0]        x3_next [LANES];
    logic [XW-1:0]        x3_reg  [LANES];

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            x3_next[i] = XW'(val2_reg) * XW'(d2_reg[i]);
        end
    end

    // ---------------- stage 4: quotient estimate for /MAXC ----------------
    // x/(2^N-1) ~ (x + x>>N + x>>2N) >> N, never high, low by at most one
    hsv2rgb_pkg::sector_t sec4_reg;
    logic [N-1:0]         val4_reg;
    logic [XW-1:0]        x4_reg   [LANES];
    logic [QW-1:0]        est4_next [LANES];
    logic [QW-1:0]        est4_reg  [LANES];

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            est4_next[i] = QW'((x3_reg[i] + (x3_reg[i] >> N) + (x3_reg[i] >> (2*N))) >> N);
        end
    end

    // ---------------- stage 5: remainder ----------------
    hsv2rgb_pkg::sector_t sec5_reg;
    logic [N-1:0]         val5_reg;
    logic [QW-1:0]        est5_reg  [LANES];
    logic [CW-1:0]        r5_next   [LANES];
    logic [CW-1:0]        r5_reg    [LANES];

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            // x - est*MAXC, with est*MAXC = (est << N) - est
            r5_next[i] = CW'(x4_reg[i] - (XW'(est4_reg[i]) << N) + XW'(est4_reg[i]));
        end
    end

    // ---------------- stage 6: corrected quotient ----------------
    hsv2rgb_pkg::sector_t sec6_reg;
    logic [N-1:0]         val6_reg;
    logic [QW-1:0]        y6_next [LANES];
    logic [QW-1:0]        y6_reg  [LANES];

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            if (r5_reg[i] >= MAXC2_C) begin
                y6_next[i] = est5_reg[i] + QW'(2);
            end else if (r5_reg[i] >= MAXC_C) begin
                y6_next[i] = est5_reg[i] + QW'(1);
            end else begin
                y6_next[i] = est5_reg[i];
            end
        end
    end

    // ---------------- stage 7: /60 by reciprocal ----------------
    hsv2rgb_pkg::sector_t sec7_reg;
    logic [N-1:0]         val7_reg;
    logic [N-1:0]         p7_next, p7_reg;
    logic [PW-1:0]        q7_next, q7_reg, t7_next, t7_reg;

    always_comb begin
        p7_next = y6_reg[LANE_P][N-1:0];
        q7_next = PW'(y6_reg[LANE_Q]) * PW'(RECIP60);
        t7_next = PW'(y6_reg[LANE_T]) * PW'(RECIP60);
    end

    // ---------------- stage 8: sector select, output word ----------------
    logic [N-1:0] q_val, t_val;
    logic [N-1:0] red_next, green_next, blue_next;
    logic [N-1:0] red_reg, green_reg, blue_reg;

    always_comb begin
        q_val = q7_reg[K+N-1:K];
        t_val = t7_reg[K+N-1:K];
        case (sec7_reg)
            hsv2rgb_pkg::SEC_0: begin
                red_next = val7_reg; green_next = t_val;    blue_next = p7_reg;
            end
            hsv2rgb_pkg::SEC_1: begin
                red_next = q_val;    green_next = val7_reg; blue_next = p7_reg;
            end
            hsv2rgb_pkg::SEC_2: begin
                red_next = p7_reg;   green_next = val7_reg; blue_next = t_val;
            end
            hsv2rgb_pkg::SEC_3: begin
                red_next = p7_reg;   green_next = q_val;    blue_next = val7_reg;
            end
            hsv2rgb_pkg::SEC_4: begin
                red_next = t_val;    green_next = p7_reg;   blue_next = val7_reg;
            end
            default: begin
                red_next = val7_reg; green_next = p7_reg;   blue_next = q_val;
            end
        endcase
    end

    assign m_tdata = OTW'({blue_reg, green_reg, red_reg});

    // ---------------- payload registers ----------------
    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            sec1_reg <= sec1_next;
            rem1_reg <= rem1_next;
            sat1_reg <= sat1_next;
            val1_reg <= val1_next;
        end
        if (stage_en[1]) begin
            sec2_reg <= sec1_reg;
            val2_reg <= val1_reg;
            d2_reg   <= d2_next;
        end
        if (stage_en[2]) begin
            sec3_reg <= sec2_reg;
            val3_reg <= val2_reg;
            x3_reg   <= x3_next;
        end
        if (stage_en[3]) begin
            sec4_reg <= sec3_reg;
            val4_reg <= val3_reg;
            x4_reg   <= x3_reg;
            est4_reg <= est4_next;
        end
        if (stage_en[4]) begin
            sec5_reg <= sec4_reg;
            val5_reg <= val4_reg;
            est5_reg <= est4_reg;
            r5_reg   <= r5_next;
        end
        if (stage_en[5]) begin
            sec6_reg <= sec5_reg;
            val6_reg <= val5_reg;
            y6_reg   <= y6_next;
        end
        if (stage_en[6]) begin
            sec7_reg <= sec6_reg;
            val7_reg <= val6_reg;
            p7_reg   <= p7_next;
            q7_reg   <= q7_next;
            t7_reg   <= t7_next;
        end
        if (stage_en[7]) begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

`ifndef SYNTHESIS
    // any empty stage must leave room at the input
    a_bubble_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !(&vld_reg) |-> s_tready)
        else $error("input stalled with a bubble in the pipeline");

    // words in flight change only through the handshakes
    a_conserve: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tvalid && s_tready) && !(m_tvalid && m_tready)
        |=> $countones(vld_reg) == $past($countones(vld_reg)))
        else $error("word lost or duplicated inside the pipeline");

    // hue remainder inside one sector
    a_rem_range: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[0] |-> rem1_reg < SEC_DEG_R)
        else $error("hue remainder out of sector");

    // corrected /MAXC quotients stay within their bounds
    a_quot_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[5] |-> (y6_reg[LANE_P] <= QW'(val6_reg))
            && (y6_reg[LANE_Q] <= QW'(60) * QW'(val6_reg))
            && (y6_reg[LANE_T] <= QW'(60) * QW'(val6_reg)))
        else $error("divide correction overshoot");
`endif

endmodule

`default_nettype wire

/* verif/tb_hsv_to_rgb_converter.sv */
// Self-checking testbench for the HSV to RGB pixel converter.
`default_nettype none

module tb_hsv_to_rgb_converter;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB         = hsv2rgb_pkg::COLOR_BITS_DEF;
    localparam int HUE_W      = hsv2rgb_pkg::HUE_W;
    localparam int HUE_WRAP   = hsv2rgb_pkg::HUE_WRAP;
    localparam int SECTOR_DEG = hsv2rgb_pkg::SECTOR_DEG;
    localparam int S_W     = ((HUE_W + 2 * CB + 7) / 8) * 8;
    localparam int M_W     = ((3 * CB + 7) / 8) * 8;
    localparam int HUE_MAX = (1 << HUE_W) - 1;
    localparam int CODE_MAX = (1 << CB) - 1;

    // no handshake on either side for this many cycles ends the run
    localparam int IDLE_LIMIT = 2000;
    // drain time after the last expected word; pipeline is 8 deep
    localparam int DRAIN_CYCLES = 24;

    typedef struct packed {
        logic [CB-1:0]    val;
        logic [CB-1:0]    sat;
        logic [HUE_W-1:0] hue;
    } hsv_pixel_t;

    typedef struct packed {
        logic [CB-1:0] blue;
        logic [CB-1:0] green;
        logic [CB-1:0] red;
    } rgb_pixel_t;

    // Expected RGB words in order, plus the color math that produces them.
    class rgb_scoreboard;
        rgb_pixel_t pending[$];
        int         errors;
        int         checked;

        function new();
            errors  = 0;
            checked = 0;
        endfunction

        // six-sector conversion with truncating integer divides
        function rgb_pixel_t hsv_to_rgb(hsv_pixel_t px);
            longint unsigned      h, s, v, rem, full, den, p, q, t;
            hsv2rgb_pkg::sector_t sec;
            rgb_pixel_t           rgb;
            h    = px.hue;
            s    = px.sat;
            v    = px.val;
            full = CODE_MAX;
            if (h >= HUE_WRAP) begin
                h = h - HUE_WRAP;
            end
            sec = hsv2rgb_pkg::sector_t'(h / SECTOR_DEG);
            rem = h % SECTOR_DEG;
            den = SECTOR_DEG * full;
            p   = (v * (full - s)) / full;
            q   = (v * (den - s * rem)) / den;
            t   = (v * (den - s * (SECTOR_DEG - rem))) / den;
            case (sec)
                hsv2rgb_pkg::SEC_0: begin
                    rgb.red = v[CB-1:0]; rgb.green = t[CB-1:0]; rgb.blue = p[CB-1:0];
                end
                hsv2rgb_pkg::SEC_1: begin
                    rgb.red = q[CB-1:0]; rgb.green = v[CB-1:0]; rgb.blue = p[CB-1:0];
                end
                hsv2rgb_pkg::SEC_2: begin
                    rgb.red = p[CB-1:0]; rgb.green = v[CB-1:0]; rgb.blue = t[CB-1:0];
                end
                hsv2rgb_pkg::SEC_3: begin
                    rgb.red = p[CB-1:0]; rgb.green = q[CB-1:0]; rgb.blue = v[CB-1:0];
                end
                hsv2rgb_pkg::SEC_4: begin
                    rgb.red = t[CB-1:0]; rgb.green = p[CB-1:0]; rgb.blue = v[CB-1:0];
                end
                default: begin
                    rgb.red = v[CB-1:0]; rgb.green = p[CB-1:0]; rgb.blue = q[CB-1:0];
                end
            endcase
            return rgb;
        endfunction

        function void note_pixel(hsv_pixel_t px);
            pending.push_back(hsv_to_rgb(px));
        endfunction

        function void check_rgb(logic [M_W-1:0] word);
            rgb_pixel_t want;
            rgb_pixel_t got;
            got = word[3*CB-1:0];
            checked++;
            if (pending.size() == 0) begin
                $error("result word %0h with no pixel outstanding", word);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.red !== want.red) begin
                $error("red: expected %0d, got %0d", want.red, got.red);
                errors++;
            end
            if (got.green !== want.green) begin
                $error("green: expected %0d, got %0d", want.green, got.green);
                errors++;
            end
            if (got.blue !== want.blue) begin
                $error("blue: expected %0d, got %0d", want.blue, got.blue);
                errors++;
            end
        endfunction
    endclass

    logic           aclk;
    logic           aresetn  = 1'b0;
    // hue_deg[8:0], saturation[16:9], brightness[24:17], zero pad
    logic [S_W-1:0] s_tdata  = '0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    // red[7:0], green[15:8], blue[23:16]
    logic [M_W-1:0] m_tdata;
    logic           m_tvalid;
    logic           m_tready = 1'b0;

    rgb_scoreboard sb;

    // idling knobs, flipped per phase by the main sequence
    bit src_gaps    = 1'b0;
    bit sink_stalls = 1'b0;

    int pixels_sent  = 0;
    int hue_wraps    = 0;
    int grey_pixels  = 0;

    hsv_to_rgb_converter #(
        .COLOR_BITS(CB)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tdata (m_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Present one pixel and hold it until the converter takes it. A random
    // gap may come first while src_gaps is set. Handshake signals are read right
    // after the edge, so they hold their pre-edge values.
    task automatic send_pixel(input hsv_pixel_t px);
        logic [S_W-1:0] word;
        if (src_gaps && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        word             = '0;
        word[HUE_W+2*CB-1:0] = px;
        s_tdata  <= word;
        s_tvalid <= 1'b1;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        sb.note_pixel(px);
        pixels_sent++;
        if (px.hue >= HUE_WRAP) hue_wraps++;
        if (px.sat == 0) grey_pixels++;
    endtask

    task automatic send_hsv(input int hue, input int sat, input int val);
        hsv_pixel_t px;
        px.hue = hue[HUE_W-1:0];
        px.sat = sat[CB-1:0];
        px.val = val[CB-1:0];
        send_pixel(px);
    endtask

    // corners of every sector, the hue wrap, grey, black and full white
    task automatic send_directed();
        int edges_deg[12] = '{0, 59, 60, 119, 120, 179, 180, 239, 240, 299, 300, 359};
        foreach (edges_deg[i]) begin
            send_hsv(edges_deg[i], CODE_MAX, CODE_MAX);
        end
        send_hsv(HUE_WRAP, CODE_MAX, CODE_MAX);   // 360 behaves as 0
        send_hsv(HUE_WRAP + 1, 200, 180);         // past 360 wraps once
        send_hsv(HUE_MAX, CODE_MAX, CODE_MAX);    // largest hue code
        send_hsv(90, 0, 200);                     // grey
        send_hsv(330, 0, CODE_MAX);               // white
        send_hsv(210, CODE_MAX, 0);               // black
        send_hsv(0, 0, 0);
        send_hsv(30, 1, 1);
        send_hsv(150, 128, 127);
        send_hsv(270, 127, 128);
        send_hsv(45, 170, 85);
    endtask

    // Mostly in-range hues; a tenth at 360 or above; codes lean toward the ends.
    task automatic send_random(input int count);
        hsv_pixel_t px;
        repeat (count) begin
            if ($urandom_range(0, 9) == 0) begin
                px.hue = HUE_W'($urandom_range(HUE_WRAP, HUE_MAX));
            end else begin
                px.hue = HUE_W'($urandom_range(0, HUE_WRAP));
            end
            case ($urandom_range(0, 7))
                0:       px.sat = '0;
                1:       px.sat = CB'(CODE_MAX);
                default: px.sat = CB'($urandom_range(0, CODE_MAX));
            endcase
            case ($urandom_range(0, 7))
                0:       px.val = '0;
                1:       px.val = CB'(CODE_MAX);
                default: px.val = CB'($urandom_range(0, CODE_MAX));
            endcase
            send_pixel(px);
        end
    endtask

    // Result side: check each accepted word, then choose ready for the next
    // edge. While sink_stalls is set, a random stall may hold ready low.
    initial begin
        int stall_left;
        stall_left = 0;
        @(posedge aclk iff aresetn);
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                sb.check_rgb(m_tdata);
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= (stall_left == 0);
            end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 13);
                m_tready   <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: too long without a word moving on either side.
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        @(posedge aclk iff aresetn);
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: %0d words still expected", sb.pending.size());
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Main sequence
    initial begin
        sb = new();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed words, then random ones, under full idling on both sides
        src_gaps    = 1'b1;
        sink_stalls = 1'b1;
        send_directed();
        send_random(300);

        // input gaps only, output always ready
        sink_stalls = 1'b0;
        send_random(180);

        // output stalls only, input back to back
        src_gaps    = 1'b0;
        sink_stalls = 1'b1;
        send_random(200);

        // closing stretch at full rate, no idling at all
        sink_stalls = 1'b0;
        send_random(170);
        s_tvalid <= 1'b0;

        while (sb.pending.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Converted %0d pixels across all six sectors, %0d past 360 deg, %0d grey.",
                 pixels_sent, hue_wraps, grey_pixels);
        $display("Checked %0d RGB words with input gaps and output stalls; %0d mismatches.",
                 sb.checked, sb.errors);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire
